// File: hdl/vhft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhft_pkg
// Shared types, codes and constants of the VPN handshake flow tracker.
// ----------------------------------------------------------------------------
package vhft_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [3:0] UDP_OPCODE_OFFSET = 4'd0;
  localparam logic [3:0] TCP_OPCODE_OFFSET = 4'd2;

  localparam logic [1:0] TK_UDP = 2'd0;
  localparam logic [1:0] TK_TCP = 2'd1;

  localparam logic [1:0] IPV_4 = 2'd0;
  localparam logic [1:0] IPV_6 = 2'd1;

  localparam logic [1:0] CFG_INVALID_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MIN_PACKETS   = 2'd1;
  localparam logic [1:0] CFG_SHARE_PERCENT = 2'd2;

  localparam logic [7:0]  RST_INVALID_LIMIT = 8'd4;
  localparam logic [15:0] RST_MIN_PACKETS   = 16'd20;
  localparam logic [6:0]  RST_SHARE_PERCENT = 7'd60;

  localparam logic [7:0] TLS_HANDSHAKE    = 8'h16;
  localparam logic [7:0] TLS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] TLS_SERVER_HELLO = 8'h02;

  // length bounds past the opcode offset for the hello probes
  localparam logic [16:0] PROBE_CH_NEAR = 17'd19;
  localparam logic [16:0] PROBE_CH_FAR  = 17'd47;
  localparam logic [16:0] PROBE_SH_NEAR = 17'd31;
  localparam logic [16:0] PROBE_SH_FAR  = 17'd59;

  localparam int unsigned NumW       = 39;
  localparam int unsigned DivSteps   = 7;
  localparam int unsigned ScoreScale = 80;
  localparam int unsigned PctScale   = 100;
  localparam logic [6:0]  SCORE_FULL = 7'd100;

  // OpenVPN opcodes
  localparam logic [4:0] OP_NONE          = 5'd0;
  localparam logic [4:0] OP_RESET_CLI_V1  = 5'd1;
  localparam logic [4:0] OP_RESET_SRV_V1  = 5'd2;
  localparam logic [4:0] OP_CONTROL_V1    = 5'd4;
  localparam logic [4:0] OP_ACK_V1        = 5'd5;
  localparam logic [4:0] OP_DATA_V1       = 5'd6;
  localparam logic [4:0] OP_RESET_CLI_V2  = 5'd7;
  localparam logic [4:0] OP_RESET_SRV_V2  = 5'd8;
  localparam logic [4:0] OP_DATA_V2       = 5'd9;
  localparam logic [4:0] OP_RESET_CLI_V3  = 5'd10;

  typedef enum logic [2:0] {
    PH_NULL,
    PH_CLIENT_RESET,
    PH_SERVER_RESET,
    PH_ACK,
    PH_CLIENT_HELLO,
    PH_SERVER_HELLO,
    PH_CONTROL_ACK,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [4:0]  op;
    logic        ignore;
    logic        client_hello;
    logic        server_hello;
    logic [1:0]  ver;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } item_t;

  typedef struct packed {
    logic [7:0]  invalid_limit;
    logic [15:0] min_packets;
    logic [6:0]  share_pct;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic mul;
    logic div;
    logic load;
  } bk_ctl_t;

endpackage

// File: hdl/vpn_handshake_flow_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpn_handshake_flow_tracker_core
// Follows one flow's packets through the OpenVPN handshake, keeps packet
// counters and gives the export score with every packet.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o   packet fields
//   out      source     out_valid_o/out_ready_i state, counters, score
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each packet passes through the back end in order: the state update, the
// score products, the quotient (one bit per cycle of the restoring divider)
// and the load of the result register, which waits while a result is held.
// The input takes beats while the queue has room, also while a result waits.
// Reset clears state, counters and queue; configuration returns to defaults.
// cfg_ready_o is always high; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module vpn_handshake_flow_tracker_core #(
  parameter int unsigned QUEUE_DEPTH = vhft_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  transport_kind_i,
  input  logic [1:0]  ip_version_i,
  input  logic [15:0] payload_len_i,
  input  logic [7:0]  opcode_byte_i,
  input  logic [63:0] probe_bytes_i,
  input  logic [63:0] src_ip_high_i,
  input  logic [63:0] src_ip_low_i,
  input  logic [63:0] dst_ip_high_i,
  input  logic [63:0] dst_ip_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  handshake_state_o,
  output logic [31:0] packet_total_o,
  output logic [31:0] data_packet_total_o,
  output logic [6:0]  vpn_score_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import vhft_pkg::*;

  cfg_t  cfg_q;
  item_t front_item, head_item;
  logic  q_full, q_valid, q_pop, push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign push        = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invalid_limit <= RST_INVALID_LIMIT;
      cfg_q.min_packets   <= RST_MIN_PACKETS;
      cfg_q.share_pct     <= RST_SHARE_PERCENT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INVALID_LIMIT: cfg_q.invalid_limit <= cfg_data_i[7:0];
        CFG_MIN_PACKETS:   cfg_q.min_packets   <= cfg_data_i;
        CFG_SHARE_PERCENT: cfg_q.share_pct     <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  vhft_front u_front (
    .transport_kind_i (transport_kind_i),
    .ip_version_i     (ip_version_i),
    .payload_len_i    (payload_len_i),
    .opcode_byte_i    (opcode_byte_i),
    .probe_bytes_i    (probe_bytes_i),
    .src_ip_high_i    (src_ip_high_i),
    .src_ip_low_i     (src_ip_low_i),
    .dst_ip_high_i    (dst_ip_high_i),
    .dst_ip_low_i     (dst_ip_low_i),
    .item_o           (front_item)
  );

  vhft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head_item),
    .valid_o (q_valid)
  );

  vhft_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .head_i              (head_item),
    .head_valid_i        (q_valid),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .handshake_state_o   (handshake_state_o),
    .packet_total_o      (packet_total_o),
    .data_packet_total_o (data_packet_total_o),
    .vpn_score_o         (vpn_score_o)
  );

endmodule

// File: hdl/vhft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhft_front
// Classifies a packet beat: extracts the opcode and flags ignored packets and
// TLS hello probes; the core pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module vhft_front (
  input  logic [1:0]      transport_kind_i,
  input  logic [1:0]      ip_version_i,
  input  logic [15:0]     payload_len_i,
  input  logic [7:0]      opcode_byte_i,
  input  logic [63:0]     probe_bytes_i,
  input  logic [63:0]     src_ip_high_i,
  input  logic [63:0]     src_ip_low_i,
  input  logic [63:0]     dst_ip_high_i,
  input  logic [63:0]     dst_ip_low_i,
  output vhft_pkg::item_t item_o
);
  import vhft_pkg::*;

  logic [3:0]  off;
  logic [16:0] len_ext;
  logic [16:0] off_ext;

  always_comb begin
    item_o        = '0;
    off           = UDP_OPCODE_OFFSET;
    item_o.op     = OP_NONE;
    item_o.ignore = 1'b0;
    unique case (transport_kind_i)
      TK_UDP: begin
        off           = UDP_OPCODE_OFFSET;
        item_o.ignore = payload_len_i <= 16'(off);
        item_o.op     = opcode_byte_i[7:3];
      end
      TK_TCP: begin
        off           = TCP_OPCODE_OFFSET;
        item_o.ignore = payload_len_i <= 16'(off);
        item_o.op     = opcode_byte_i[7:3];
      end
      default: begin
        off = UDP_OPCODE_OFFSET;
      end
    endcase

    len_ext = {1'b0, payload_len_i};
    off_ext = 17'(off);

    item_o.client_hello =
        (len_ext > off_ext + PROBE_CH_NEAR && probe_bytes_i[7:0] == TLS_HANDSHAKE &&
         probe_bytes_i[15:8] == TLS_CLIENT_HELLO) ||
        (len_ext > off_ext + PROBE_CH_FAR && probe_bytes_i[23:16] == TLS_HANDSHAKE &&
         probe_bytes_i[31:24] == TLS_CLIENT_HELLO);
    item_o.server_hello =
        (len_ext > off_ext + PROBE_SH_NEAR && probe_bytes_i[39:32] == TLS_HANDSHAKE &&
         probe_bytes_i[47:40] == TLS_SERVER_HELLO) ||
        (len_ext > off_ext + PROBE_SH_FAR && probe_bytes_i[55:48] == TLS_HANDSHAKE &&
         probe_bytes_i[63:56] == TLS_SERVER_HELLO);

    item_o.ver    = ip_version_i;
    item_o.src_hi = src_ip_high_i;
    item_o.src_lo = src_ip_low_i;
    item_o.dst_hi = dst_ip_high_i;
    item_o.dst_lo = dst_ip_low_i;
  end

endmodule

// File: hdl/vhft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhft_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module vhft_queue #(
  parameter int unsigned DEPTH = vhft_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vhft_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output vhft_pkg::item_t head_o,
  output logic            valid_o
);
  import vhft_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/vhft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhft_back
// Handshake state machine, saturating counters and score unit: multiplies,
// then a seven step restoring divide for the partial score, then a result
// register toward the output channel.
// ----------------------------------------------------------------------------
module vhft_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vhft_pkg::cfg_t  cfg_i,
  input  vhft_pkg::item_t head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      handshake_state_o,
  output logic [31:0]     packet_total_o,
  output logic [31:0]     data_packet_total_o,
  output logic [6:0]      vpn_score_o
);
  import vhft_pkg::*;

  bk_state_e state_q, state_d;
  bk_ctl_t   ctl;

  phase_e      phase_q, phase_d;
  logic [63:0] client_hi_q, client_hi_d;
  logic [63:0] client_lo_q, client_lo_d;
  logic [7:0]  unmatched_q, unmatched_d;
  logic [31:0] all_q, all_d;
  logic [31:0] data_q, data_d;

  logic [NumW-1:0] share_q, need_q, rem_q, rem_d, trial;
  logic [6:0]      quo_q, quo_d;
  logic [2:0]      cnt_q;

  logic        out_valid_q;
  logic [2:0]  out_state_q;
  logic [31:0] out_all_q, out_data_q;
  logic [6:0]  out_score_q;
  logic [6:0]  score;

  logic              match_src, match_dst, unmatched;
  logic signed [9:0] v, lim;

  function automatic logic addr_match(logic [1:0] ver, logic [63:0] hi, logic [63:0] lo,
                                      logic [63:0] c_hi, logic [63:0] c_lo);
    logic m;
    m = 1'b0;
    if (ver == IPV_4) begin
      m = c_lo[31:0] == lo[31:0];
    end else if (ver == IPV_6) begin
      m = (c_lo == lo) && (c_hi == hi);
    end
    return m;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (head_valid_i) state_d = BK_MUL;
      BK_MUL:  state_d = BK_DIV;
      BK_DIV:  if (cnt_q == '0) state_d = BK_DONE;
      BK_DONE: if (!out_valid_q || out_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.pop  = (state_q == BK_IDLE) && head_valid_i;
    ctl.mul  = state_q == BK_MUL;
    ctl.div  = state_q == BK_DIV;
    ctl.load = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);
  end

  assign pop_o = ctl.pop;

  always_comb begin
    phase_d     = phase_q;
    client_hi_d = client_hi_q;
    client_lo_d = client_lo_q;
    data_d      = data_q;
    all_d       = all_q;
    unmatched   = 1'b0;
    v           = signed'({2'b00, unmatched_q});
    lim         = signed'({2'b00, cfg_i.invalid_limit});
    match_src   = addr_match(head_i.ver, head_i.src_hi, head_i.src_lo, client_hi_q, client_lo_q);
    match_dst   = addr_match(head_i.ver, head_i.dst_hi, head_i.dst_lo, client_hi_q, client_lo_q);

    unique case (head_i.op)
      OP_RESET_CLI_V1, OP_RESET_CLI_V2, OP_RESET_CLI_V3: begin
        phase_d     = PH_CLIENT_RESET;
        v           = -10'sd1;
        client_hi_d = head_i.src_hi;
        client_lo_d = head_i.src_lo;
      end
      OP_RESET_SRV_V1, OP_RESET_SRV_V2: begin
        if (phase_q == PH_CLIENT_RESET && match_dst) begin
          phase_d = PH_SERVER_RESET;
          v       = -10'sd1;
        end else begin
          unmatched = 1'b1;
        end
      end
      OP_CONTROL_V1: begin
        if (phase_q == PH_ACK && match_src && head_i.client_hello) begin
          phase_d = PH_CLIENT_HELLO;
          v       = -10'sd1;
        end else if (phase_q == PH_CLIENT_HELLO && match_dst && head_i.server_hello) begin
          phase_d = PH_SERVER_HELLO;
          v       = -10'sd1;
        end else if (phase_q == PH_SERVER_HELLO || phase_q == PH_CONTROL_ACK) begin
          phase_d = PH_CONTROL_ACK;
          v       = -10'sd1;
        end else begin
          unmatched = 1'b1;
        end
      end
      OP_ACK_V1: begin
        if (phase_q == PH_SERVER_RESET && match_src) begin
          phase_d = PH_ACK;
          v       = -10'sd1;
        end else if (phase_q == PH_SERVER_HELLO || phase_q == PH_CONTROL_ACK) begin
          phase_d = PH_CONTROL_ACK;
          v       = -10'sd1;
        end
      end
      OP_DATA_V1, OP_DATA_V2: begin
        if (phase_q == PH_CONTROL_ACK || phase_q == PH_DATA) begin
          phase_d = PH_DATA;
          v       = -10'sd1;
        end
        if (data_q != '1) data_d = data_q + 32'd1;
      end
      default: begin
      end
    endcase

    if (unmatched) begin
      v = v + 10'sd1;
      if (v == lim) phase_d = PH_NULL;
    end
    if (all_q != '1) all_d = all_q + 32'd1;
    if (v >= lim) begin
      phase_d = PH_NULL;
      v       = -10'sd1;
    end
    v           = v + 10'sd1;
    unmatched_d = v[7:0];
  end

  always_comb begin
    trial = NumW'(all_q) << cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (rem_q >= trial) begin
      rem_d        = rem_q - trial;
      quo_d[cnt_q] = 1'b1;
    end
  end

  always_comb begin
    score = '0;
    if (all_q > 32'(cfg_i.min_packets)) begin
      if (phase_q == PH_DATA) begin
        score = SCORE_FULL;
      end else if (share_q >= need_q) begin
        score = quo_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      phase_q     <= PH_NULL;
      client_hi_q <= '0;
      client_lo_q <= '0;
      unmatched_q <= '0;
      all_q       <= '0;
      data_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl.pop && !head_i.ignore) begin
        phase_q     <= phase_d;
        client_hi_q <= client_hi_d;
        client_lo_q <= client_lo_d;
        unmatched_q <= unmatched_d;
        all_q       <= all_d;
        data_q      <= data_d;
      end
      if (ctl.mul) begin
        cnt_q <= 3'(DivSteps - 1);
      end else if (ctl.div && cnt_q != '0) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (ctl.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mul) begin
      share_q <= NumW'(data_q) * NumW'(PctScale);
      need_q  <= NumW'(cfg_i.share_pct) * NumW'(all_q);
      rem_q   <= NumW'(data_q) * NumW'(ScoreScale);
      quo_q   <= '0;
    end else if (ctl.div) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (ctl.load) begin
      out_state_q <= phase_q;
      out_all_q   <= all_q;
      out_data_q  <= data_q;
      out_score_q <= score;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign handshake_state_o   = out_state_q;
  assign packet_total_o      = out_all_q;
  assign data_packet_total_o = out_data_q;
  assign vpn_score_o         = out_score_q;

  a_data_le_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_q <= all_q)
    else $error("data count above packet count");

  a_data_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> data_q != '0)
    else $error("data phase without data packets");

  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DONE && all_q != '0 |-> quo_q <= 7'(ScoreScale))
    else $error("partial score out of range");

endmodule
